// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bounding box accumulator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // request op codes
   localparam logic [1:0] OP_POINT  = 2'd0;
   localparam logic [1:0] OP_SPHERE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
   localparam logic signed [31:0] TEN_Q16 = 32'sd655360;

   typedef enum logic [1:0] {
      CMD_GROW,
      CMD_CLEAR,
      CMD_QUERY
   } bba_kind_type;

   typedef struct packed {
      logic [1:0]          op;
      logic signed [31:0]  pos_x;
      logic signed [31:0]  pos_y;
      logic signed [31:0]  pos_z;
      logic signed [31:0]  radius;
      logic signed [15:0]  dir_x;
      logic signed [15:0]  dir_y;
      logic signed [15:0]  dir_z;
   } bba_req_type;

   typedef struct packed {
      logic signed [31:0]  near_depth;
      logic signed [31:0]  far_depth;
      logic [30:0]         reach_x;
      logic [30:0]         reach_y;
      logic [30:0]         reach_z;
      logic [30:0]         reach_all;
      logic signed [31:0]  mid_x;
      logic signed [31:0]  mid_y;
      logic signed [31:0]  mid_z;
      logic                is_empty;
   } bba_rsp_type;

   // classified command: lo/hi bounds for a grow, lo holds the center for a query
   typedef struct packed {
      bba_kind_type              kind;
      logic [2:0][31:0]          lo;
      logic [2:0][31:0]          hi;
      logic [2:0][15:0]          dir;
   } bba_cmd_type;

   typedef struct packed {
      logic        valid;
      bba_cmd_type cmd;
   } bba_head_type;

endpackage

// File: rtl/bba_front.sv
// ----------------------------------------------------------------------------
// bba_front
// Decodes a request into a command; works out the sphere bounds.
// ----------------------------------------------------------------------------
module bba_front (
   input  bba_pkg::bba_req_type req_payload,
   output bba_pkg::bba_cmd_type cmd
);
   import bba_pkg::*;

   function automatic logic [31:0] sat33(input logic [32:0] v);
      if (v[32] == v[31]) begin
         sat33 = v[31:0];
      end else if (v[32]) begin
         sat33 = 32'h8000_0000;
      end else begin
         sat33 = 32'h7fff_ffff;
      end
   endfunction

   logic [31:0]       rad_abs;
   logic [2:0][31:0]  pos;
   logic [2:0][31:0]  sph_lo;
   logic [2:0][31:0]  sph_hi;

   assign pos[0] = req_payload.pos_x;
   assign pos[1] = req_payload.pos_y;
   assign pos[2] = req_payload.pos_z;

   // magnitude of the most negative radius clamps to the largest positive
   always_comb begin
      if (req_payload.radius == 32'sh8000_0000) begin
         rad_abs = 32'h7fff_ffff;
      end else if (req_payload.radius[31]) begin
         rad_abs = 32'(-req_payload.radius);
      end else begin
         rad_abs = req_payload.radius;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sph_lo[i] = sat33({pos[i][31], pos[i]} - {1'b0, rad_abs});
         sph_hi[i] = sat33({pos[i][31], pos[i]} + {1'b0, rad_abs});
      end
   end

   always_comb begin
      cmd.lo  = pos;
      cmd.hi  = pos;
      cmd.dir = {req_payload.dir_z, req_payload.dir_y, req_payload.dir_x};
      case (req_payload.op)
         OP_POINT: begin
            cmd.kind = CMD_GROW;
         end
         OP_SPHERE: begin
            cmd.kind = CMD_GROW;
            cmd.lo   = sph_lo;
            cmd.hi   = sph_hi;
         end
         OP_CLEAR: begin
            cmd.kind = CMD_CLEAR;
         end
         default: begin
            cmd.kind = CMD_QUERY;
         end
      endcase
   end

endmodule

// File: rtl/bba_queue.sv
// ----------------------------------------------------------------------------
// bba_queue
// Short command queue between the decode side and the box side.
// ----------------------------------------------------------------------------
module bba_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bba_pkg::bba_cmd_type cmd_in,
   output logic                 full,
   input  logic                 pop,
   output bba_pkg::bba_head_type head
);
   import bba_pkg::*;

   bba_cmd_type        entry_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   assign full       = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid) else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

// File: rtl/bba_back.sv
// ----------------------------------------------------------------------------
// bba_back
// Holds the box, applies grow and clear commands and answers queries
// through a two-register pipeline.
// ----------------------------------------------------------------------------
module bba_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bba_pkg::bba_head_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bba_pkg::bba_rsp_type  rsp_payload
);
   import bba_pkg::*;

   logic [2:0][31:0]  box_low_ff, box_low_in;
   logic [2:0][31:0]  box_high_ff, box_high_in;
   logic              empty_ff, empty_in;

   // stage one: products and per-axis terms of a query
   logic                     s1_valid_ff;
   logic [2:0][47:0]         plo_ff, phi_ff;
   logic [2:0][47:0]         plo_in, phi_in;
   logic                     degen_ff, degen_in;
   logic                     s1_empty_ff;
   logic [2:0][30:0]         reach_ff, reach_in;
   logic [2:0][31:0]         mid_ff, mid_in;

   logic                     out_valid_ff;
   bba_rsp_type              out_ff, out_in;

   logic out_free;
   logic s1_free;
   logic take_query;

   function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
      if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
         sat36 = v[31:0];
      end else if (v[35]) begin
         sat36 = 32'sh8000_0000;
      end else begin
         sat36 = 32'sh7fff_ffff;
      end
   endfunction

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_free    = !s1_valid_ff || out_free;
   assign pop        = head.valid && ((head.cmd.kind != CMD_QUERY) || s1_free);
   assign take_query = pop && (head.cmd.kind == CMD_QUERY);

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // box update
   always_comb begin
      box_low_in  = box_low_ff;
      box_high_in = box_high_ff;
      empty_in    = empty_ff;
      if (pop) begin
         case (head.cmd.kind)
            CMD_GROW: begin
               for (int i = 0; i < 3; i++) begin
                  if (empty_ff || ($signed(head.cmd.lo[i]) < $signed(box_low_ff[i]))) begin
                     box_low_in[i] = head.cmd.lo[i];
                  end
                  if (empty_ff || ($signed(head.cmd.hi[i]) > $signed(box_high_ff[i]))) begin
                     box_high_in[i] = head.cmd.hi[i];
                  end
               end
               empty_in = 1'b0;
            end
            CMD_CLEAR: begin
               box_low_in  = '0;
               box_high_in = '0;
               empty_in    = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // stage one terms from the current box
   always_comb begin
      logic [32:0] da, db;
      logic [32:0] ma, mb, mm;
      logic [32:0] sum;
      degen_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         plo_in[i] = 48'($signed(box_low_ff[i]) * $signed(head.cmd.dir[i]));
         phi_in[i] = 48'($signed(box_high_ff[i]) * $signed(head.cmd.dir[i]));
         if (box_low_ff[i] != box_high_ff[i]) begin
            degen_in = 1'b0;
         end
         da = {head.cmd.lo[i][31], head.cmd.lo[i]} - {box_low_ff[i][31], box_low_ff[i]};
         db = {head.cmd.lo[i][31], head.cmd.lo[i]} - {box_high_ff[i][31], box_high_ff[i]};
         ma = da[32] ? 33'(-da) : da;
         mb = db[32] ? 33'(-db) : db;
         mm = (mb > ma) ? mb : ma;
         reach_in[i] = (mm[32:31] != 2'b00) ? 31'h7fff_ffff : mm[30:0];
         sum = {box_low_ff[i][31], box_low_ff[i]} + {box_high_ff[i][31], box_high_ff[i]};
         mid_in[i] = sum[32:1];
      end
   end

   // stage two: separable corner min/max, scale and saturate
   always_comb begin
      logic signed [49:0] smin, smax;
      logic signed [35:0] nsh, fsh;
      logic [30:0]        rall;
      smin = '0;
      smax = '0;
      for (int i = 0; i < 3; i++) begin
         if ($signed(plo_ff[i]) < $signed(phi_ff[i])) begin
            smin = smin + 50'($signed(plo_ff[i]));
            smax = smax + 50'($signed(phi_ff[i]));
         end else begin
            smin = smin + 50'($signed(phi_ff[i]));
            smax = smax + 50'($signed(plo_ff[i]));
         end
      end
      nsh = smin[49:14];
      fsh = smax[49:14];
      rall = reach_ff[0];
      if (reach_ff[1] > rall) begin
         rall = reach_ff[1];
      end
      if (reach_ff[2] > rall) begin
         rall = reach_ff[2];
      end

      if (degen_ff) begin
         out_in.near_depth = ONE_Q16;
         out_in.far_depth  = TEN_Q16;
      end else begin
         out_in.near_depth = sat36(nsh);
         out_in.far_depth  = sat36(fsh);
      end
      if (s1_empty_ff) begin
         out_in.reach_x   = '0;
         out_in.reach_y   = '0;
         out_in.reach_z   = '0;
         out_in.reach_all = '0;
         out_in.mid_x     = '0;
         out_in.mid_y     = '0;
         out_in.mid_z     = '0;
         out_in.is_empty  = 1'b1;
      end else begin
         out_in.reach_x   = reach_ff[0];
         out_in.reach_y   = reach_ff[1];
         out_in.reach_z   = reach_ff[2];
         out_in.reach_all = rall;
         out_in.mid_x     = mid_ff[0];
         out_in.mid_y     = mid_ff[1];
         out_in.mid_z     = mid_ff[2];
         out_in.is_empty  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_low_ff   <= '0;
         box_high_ff  <= '0;
         empty_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         box_low_ff  <= box_low_in;
         box_high_ff <= box_high_in;
         empty_ff    <= empty_in;
         if (s1_free) begin
            s1_valid_ff <= take_query;
         end
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_query) begin
         plo_ff      <= plo_in;
         phi_ff      <= phi_in;
         degen_ff    <= degen_in;
         s1_empty_ff <= empty_ff;
         reach_ff    <= reach_in;
         mid_ff      <= mid_in;
      end
      if (out_free && s1_valid_ff) begin
         out_ff <= out_in;
      end
   end

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (pop && head.cmd.kind == CMD_CLEAR) |=> empty_ff && box_low_ff == '0
      && box_high_ff == '0) else $error("clear did not empty the box");
   a_grow_ordered: assert property (@(posedge clock) disable iff (reset)
      (pop && head.cmd.kind == CMD_GROW) |=> !empty_ff
      && $signed(box_low_ff[0]) <= $signed(box_high_ff[0])
      && $signed(box_low_ff[1]) <= $signed(box_high_ff[1])
      && $signed(box_low_ff[2]) <= $signed(box_high_ff[2]))
      else $error("box bounds out of order after grow");
   a_query_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && rsp_stall) |-> !take_query)
      else $error("query taken while pipeline blocked");
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |=> out_valid_ff)
      else $error("stage one result dropped");

endmodule

// File: rtl/bounding_box_accumulator.sv
// ----------------------------------------------------------------------------
// bounding_box_accumulator
// Axis-aligned 3D box in Q16.16: add point, add sphere, clear and query.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  req_     | in        | req_valid/req_stall | bba_req_type
//  rsp_     | out       | rsp_valid/rsp_stall | bba_rsp_type (queries only)
//
// one transaction per cycle is taken and retired, sustained while no stall holds the flow
// a query answer goes queue, stage one, output register, each a register;
// the six 32x16 products sit in stage one
// reset is synchronous and empties the box and the queue
// req_stall is high only while the queue is full; a stalled response
// backs up stage one, then the queue
// ----------------------------------------------------------------------------
module bounding_box_accumulator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bba_pkg::bba_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bba_pkg::bba_rsp_type rsp_payload
);
   import bba_pkg::*;

   bba_cmd_type  cmd;
   bba_head_type head;
   logic         q_full;
   logic         push;
   logic         pop;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   bba_front u_front (
      .req_payload (req_payload),
      .cmd         (cmd)
   );

   bba_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .cmd_in (cmd),
      .full   (q_full),
      .pop    (pop),
      .head   (head)
   );

   bba_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounding box accumulator. Directed items hit
// the field extremes, saturation, flat and empty boxes; random rounds of
// clear, grow and query follow. A shadow copy of the box predicts each query
// answer, and answers are compared in order as they leave the block.
// ----------------------------------------------------------------------------
module testbench;
   import bba_pkg::*;

   class box_shadow;
      logic signed [31:0] box_lo [3];
      logic signed [31:0] box_hi [3];
      bit                 empty;
      bba_rsp_type        query_answers [$];
      int                 errors;

      function new();
         errors = 0;
         clear_box();
      endfunction

      function void clear_box();
         for (int i = 0; i < 3; i++) begin
            box_lo[i] = '0;
            box_hi[i] = '0;
         end
         empty = 1'b1;
      endfunction

      function logic signed [31:0] sat32(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function void grow(logic signed [31:0] lo [3], logic signed [31:0] hi [3]);
         for (int i = 0; i < 3; i++) begin
            if (empty || lo[i] < box_lo[i]) box_lo[i] = lo[i];
            if (empty || hi[i] > box_hi[i]) box_hi[i] = hi[i];
         end
         empty = 1'b0;
      endfunction

      // update the box for one accepted transaction, queue the answer of a query
      function void note_request(bba_req_type r);
         logic signed [31:0] pos [3];
         logic signed [31:0] lo [3];
         logic signed [31:0] hi [3];
         longint dir [3];
         longint reach [3];
         longint mid [3];
         longint rad, p, a, b, c, sum, mn, mx, widest;
         bit flat;
         bba_rsp_type ans;
         pos[0] = r.pos_x;
         pos[1] = r.pos_y;
         pos[2] = r.pos_z;
         dir[0] = $signed(r.dir_x);
         dir[1] = $signed(r.dir_y);
         dir[2] = $signed(r.dir_z);
         case (r.op)
            OP_POINT: grow(pos, pos);
            OP_SPHERE: begin
               rad = $signed(r.radius);
               if (rad < 0) rad = -rad;
               if (rad > 64'sd2147483647) rad = 64'sd2147483647;
               for (int i = 0; i < 3; i++) begin
                  p = pos[i];
                  lo[i] = sat32(p - rad);
                  hi[i] = sat32(p + rad);
               end
               grow(lo, hi);
            end
            OP_CLEAR: clear_box();
            default: begin
               ans = '0;
               flat = 1'b1;
               for (int i = 0; i < 3; i++)
                  if (box_lo[i] != box_hi[i]) flat = 1'b0;
               if (flat) begin
                  ans.near_depth = ONE_Q16;
                  ans.far_depth = TEN_Q16;
               end else begin
                  mn = 0;
                  mx = 0;
                  for (int k = 0; k < 8; k++) begin
                     sum = 0;
                     for (int i = 0; i < 3; i++) begin
                        c = ((k >> i) & 1) ? box_hi[i] : box_lo[i];
                        sum += c * dir[i];
                     end
                     if (k == 0 || sum < mn) mn = sum;
                     if (k == 0 || sum > mx) mx = sum;
                  end
                  // arithmetic shift floors toward minus infinity
                  ans.near_depth = sat32(mn >>> 14);
                  ans.far_depth = sat32(mx >>> 14);
               end
               ans.is_empty = empty;
               if (!empty) begin
                  widest = 0;
                  for (int i = 0; i < 3; i++) begin
                     p = pos[i];
                     a = p - box_lo[i];
                     b = p - box_hi[i];
                     if (a < 0) a = -a;
                     if (b < 0) b = -b;
                     if (b > a) a = b;
                     if (a > 64'sd2147483647) a = 64'sd2147483647;
                     reach[i] = a;
                     if (a > widest) widest = a;
                     a = box_lo[i];
                     b = box_hi[i];
                     mid[i] = (a + b) >>> 1;
                  end
                  ans.reach_x = 31'(reach[0]);
                  ans.reach_y = 31'(reach[1]);
                  ans.reach_z = 31'(reach[2]);
                  ans.reach_all = 31'(widest);
                  ans.mid_x = 32'(mid[0]);
                  ans.mid_y = 32'(mid[1]);
                  ans.mid_z = 32'(mid[2]);
               end
               query_answers.push_back(ans);
            end
         endcase
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("mismatch on %s: expected %0d, actual %0d", name, want, got);
         end
      endfunction

      function void check_answer(bba_rsp_type got);
         bba_rsp_type want;
         if (query_answers.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: result with no query waiting, actual %h", got);
            return;
         end
         want = query_answers.pop_front();
         compare_field("near_depth", want.near_depth, got.near_depth);
         compare_field("far_depth", want.far_depth, got.far_depth);
         compare_field("reach_x", want.reach_x, got.reach_x);
         compare_field("reach_y", want.reach_y, got.reach_y);
         compare_field("reach_z", want.reach_z, got.reach_z);
         compare_field("reach_all", want.reach_all, got.reach_all);
         compare_field("mid_x", want.mid_x, got.mid_x);
         compare_field("mid_y", want.mid_y, got.mid_y);
         compare_field("mid_z", want.mid_z, got.mid_z);
         compare_field("is_empty", want.is_empty, got.is_empty);
      endfunction
   endclass

   localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
   localparam logic signed [31:0] MIN32 = 32'sh80000000;
   localparam int Q1 = 65536;
   localparam int ITEM_TARGET = 1850;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bba_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bba_rsp_type rsp_payload;

   box_shadow shadow = new();
   int        items_sent = 0;
   bit        tx_burst = 1'b0;

   bounding_box_accumulator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) shadow.note_request(req_payload);
         if (rsp_valid && !rsp_stall) shadow.check_answer(rsp_payload);
      end
   end

   function automatic bba_req_type make_item(logic [1:0] op, int px, int py, int pz,
                                             int rad, int dx, int dy, int dz);
      bba_req_type it;
      it.op = op;
      it.pos_x = px;
      it.pos_y = py;
      it.pos_z = pz;
      it.radius = rad;
      it.dir_x = 16'(dx);
      it.dir_y = 16'(dy);
      it.dir_z = 16'(dz);
      return it;
   endfunction

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return MAX32;
         2: return MIN32;
         3: return $urandom_range(0, 255) - 128;
         default: return $urandom_range(0, 2097152) - 1048576;
      endcase
   endfunction

   function automatic logic signed [15:0] pick_dir();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'sh7fff;
         2: return 16'sh8000;
         3: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic bba_req_type random_fields();
      bba_req_type it;
      it.op = 2'($urandom);
      it.pos_x = pick_coord();
      it.pos_y = pick_coord();
      it.pos_z = pick_coord();
      it.radius = pick_coord();
      it.dir_x = pick_dir();
      it.dir_y = pick_dir();
      it.dir_z = pick_dir();
      return it;
   endfunction

   task automatic send_item(input bba_req_type item);
      int gap;
      if (items_sent % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      gap = tx_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
   endtask

   // clear now and then, a few grows, then queries; some pure noise
   task automatic random_round();
      bba_req_type it;
      int n_add;
      int n_query;
      if ($urandom_range(0, 7) == 0) begin
         it = random_fields();
         it.pos_x = $urandom;
         it.pos_y = $urandom;
         it.pos_z = $urandom;
         it.radius = $urandom;
         it.dir_x = 16'($urandom);
         it.dir_y = 16'($urandom);
         it.dir_z = 16'($urandom);
         send_item(it);
         return;
      end
      if ($urandom_range(0, 3) == 0) begin
         it = random_fields();
         it.op = OP_CLEAR;
         send_item(it);
      end
      n_add = $urandom_range(0, 6);
      repeat (n_add) begin
         it = random_fields();
         it.op = $urandom_range(0, 1) ? OP_POINT : OP_SPHERE;
         send_item(it);
      end
      n_query = $urandom_range(1, 3);
      repeat (n_query) begin
         it = random_fields();
         it.op = OP_QUERY;
         send_item(it);
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(make_item(OP_QUERY, 0, 0, 0, 0, 16384, 0, 0));
      send_item(make_item(OP_POINT, Q1, 2 * Q1, 3 * Q1, 0, 0, 0, 0));
      // single point: flat box but not empty
      send_item(make_item(OP_QUERY, 0, 0, 0, 0, 16384, 16384, 16384));
      send_item(make_item(OP_POINT, -5 * Q1, -7 * Q1, 9 * Q1, 0, 0, 0, 0));
      send_item(make_item(OP_QUERY, MIN32, MAX32, 0, 0, -32768, 32767, 1));
      // most negative radius saturates, bounds saturate
      send_item(make_item(OP_SPHERE, MAX32, MIN32, 0, MIN32, 0, 0, 0));
      send_item(make_item(OP_QUERY, MIN32, MAX32, MIN32, 0, 32767, 32767, 32767));
      send_item(make_item(OP_QUERY, MAX32, MIN32, MAX32, 0, -32768, -32768, -32768));
      send_item(make_item(OP_CLEAR, MAX32, MAX32, MAX32, MAX32, -1, -1, -1));
      send_item(make_item(OP_QUERY, MAX32, MIN32, 7, 0, 1, 1, 1));
      // first grow after clear takes the point outright
      send_item(make_item(OP_POINT, -1, -2, -3, 0, 0, 0, 0));
      send_item(make_item(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(OP_QUERY, 0, 0, 0, 0, -1, -1, 1));
      send_item(make_item(OP_SPHERE, 0, 0, 0, -5 * Q1, 0, 0, 0));
      send_item(make_item(OP_QUERY, Q1, -Q1, 0, 0, 16384, -16384, 8192));
      send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(OP_SPHERE, 3, 3, 3, 0, 0, 0, 0));
      send_item(make_item(OP_QUERY, -3, 5, 3, 0, 100, -100, 7));
      send_item(make_item(OP_POINT, MAX32, MAX32, MAX32, 0, 0, 0, 0));
      send_item(make_item(OP_POINT, MIN32, MIN32, MIN32, 0, 0, 0, 0));
      send_item(make_item(OP_QUERY, MAX32, MIN32, 0, 0, 32767, -32768, 0));
      send_item(make_item(OP_CLEAR, -1, -1, -1, -1, 32767, 32767, 32767));

      while (items_sent < ITEM_TARGET) random_round();
      req_valid <= 1'b0;

      while (shadow.query_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (shadow.errors == 0 && shadow.query_answers.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin : result_side
      int  gap;
      int  taken;
      bit  rx_burst;
      taken = 0;
      rx_burst = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (taken % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
         gap = rx_burst ? 0 : $urandom_range(0, 11);
         // long hold-off so the queue fills and req_stall rises
         if (taken == 40 || taken == 300) gap = 150;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end
endmodule

// File: files.f
rtl/bba_pkg.sv
rtl/bba_front.sv
rtl/bba_queue.sv
rtl/bba_back.sv
rtl/bounding_box_accumulator.sv
test/testbench.sv
